/* rtl/core/dpoc_pkg.sv */
// Package for the DNA pattern occurrence counter core.
// Holds field widths, register indexes, parameter defaults and the cell control struct.
// No dependencies; imported by dpoc_cell, dpoc_checker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dpoc_pkg;

  localparam int SYM_W         = 2;
  localparam int LEN_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int SYMS_PER_WORD = CFG_DATA_W / SYM_W;
  localparam int NUM_WORDS     = 4;
  localparam int IN_DATA_W     = 8;

  localparam int DEF_MAX_PATTERN = 128;
  localparam int DEF_COUNT_WIDTH = 20;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd1;

  typedef struct packed {
    logic advance;  // item accepted: window shifts by one cell
    logic flush;    // accepted item is the last one: window clears
    logic load;     // load reversed pattern into the cells
    logic align;    // shift aligned pattern one cell toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/dpoc_cell.sv */
// One cell of the match row: holds one window symbol and one aligned pattern symbol.
// Depends on dpoc_pkg for widths and the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module dpoc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dpoc_pkg::cell_ctl_t         ctl,
  input  wire logic [dpoc_pkg::SYM_W-1:0]  win_in,
  input  wire logic [dpoc_pkg::SYM_W-1:0]  pat_in,
  input  wire logic [dpoc_pkg::SYM_W-1:0]  load_sym,
  input  wire logic                        en,
  output logic      [dpoc_pkg::SYM_W-1:0]  win,
  output logic      [dpoc_pkg::SYM_W-1:0]  pat,
  output logic                             ok
);
  import dpoc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      pat <= '0;
    end else begin
      if (ctl.advance) begin
        win <= ctl.flush ? '0 : win_in;
      end
      if (ctl.load) begin
        pat <= load_sym;
      end else if (ctl.align) begin
        pat <= pat_in;
      end
    end
  end

  // compare against the symbol this cell holds once the item has shifted in
  assign ok = !en || (win_in == pat);

endmodule

`default_nettype wire

/* rtl/core/dna_pattern_occurrence_counter_core.sv */
// A result is registered into the m_axis output register, or into the skid entry while
//   m_axis stalls. Throughput: one item per cycle while m_axis keeps up; a two-entry output
//   buffer keeps s_axis open while a result waits. After each configuration write s_axis
//   stalls while the reversed pattern loads and shifts into place.
// Reset (rst, synchronous): window, symbol and hit counts clear, pattern_length = 1,
//   pattern symbols zero. Depends on dpoc_pkg and dpoc_cell.
`timescale 1ns / 1ps
`default_nettype none

module dna_pattern_occurrence_counter_core #(
  parameter int MAX_PATTERN = dpoc_pkg::DEF_MAX_PATTERN,
  parameter int COUNT_WIDTH = dpoc_pkg::DEF_COUNT_WIDTH,
  localparam int OUT_W      = ((1 + COUNT_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [dpoc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [1:0] symbol
  input  wire logic                             s_axis_tlast,  // last_symbol
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [OUT_W-1:0]                 m_axis_tdata,  // [0] hit, then match_count
  output logic                                  m_axis_tlast,  // sequence_done
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dpoc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dpoc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dpoc_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);

  logic                   cfg_fire;
  logic                   in_fire;
  logic [LEN_W-1:0]       len_reg;
  logic                   len_ok;
  logic [SYM_W-1:0]       pat_sym  [MAX_PATTERN];
  logic [SYM_W-1:0]       win_q    [MAX_PATTERN];
  logic [SYM_W-1:0]       pat_q    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;
  cell_ctl_t              ctl;

  logic                   pend;
  logic [SEEN_W-1:0]      rem;
  logic                   busy;

  logic [SEEN_W-1:0]      seen;
  logic [SEEN_W-1:0]      seen_next;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] total_next;
  logic                   hit;

  logic                   o_valid;
  logic                   o_hit;
  logic [COUNT_WIDTH-1:0] o_count;
  logic                   o_last;
  logic                   s_valid;
  logic                   s_hit;
  logic [COUNT_WIDTH-1:0] s_count;
  logic                   s_last;
  logic                   pop;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LEN_W'(1);
    end else if (cfg_fire && cfg_index == REG_LENGTH) begin
      len_reg <= cfg_data[LEN_W-1:0];
    end
  end

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pat
    localparam int WORD = p / SYMS_PER_WORD;
    localparam int POS  = p % SYMS_PER_WORD;
    if (WORD < NUM_WORDS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          pat_sym[p] <= '0;
        end else if (cfg_fire && cfg_index == CFG_IDX_W'(32'(REG_WORD0) + WORD)) begin
          pat_sym[p] <= cfg_data[SYM_W*POS +: SYM_W];
        end
      end
    end else begin : g_none
      assign pat_sym[p] = '0;
    end
  end

  assign len_ok = (len_reg != '0) && (32'(len_reg) <= MAX_PATTERN);

  // pattern alignment: load reversed, then shift down by MAX_PATTERN - length
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      rem  <= '0;
    end else if (cfg_fire) begin
      pend <= 1'b1;
    end else if (pend) begin
      pend <= 1'b0;
      rem  <= len_ok ? SEEN_W'(MAX_PATTERN - 32'(len_reg)) : '0;
    end else if (rem != '0) begin
      rem <= rem - 1'b1;
    end
  end

  assign busy          = pend || (rem != '0);
  assign s_axis_tready = !s_valid && !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctl.advance = in_fire;
    ctl.flush   = s_axis_tlast;
    ctl.load    = pend;
    ctl.align   = !pend && (rem != '0);
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [SYM_W-1:0] w_in;
    logic [SYM_W-1:0] p_in;
    if (i == 0) begin : g_head
      assign w_in = s_axis_tdata[SYM_W-1:0];
    end else begin : g_mid
      assign w_in = win_q[i-1];
    end
    if (i == MAX_PATTERN - 1) begin : g_tail
      assign p_in = '0;
    end else begin : g_body
      assign p_in = pat_q[i+1];
    end
    dpoc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .win_in   (w_in),
      .pat_in   (p_in),
      .load_sym (pat_sym[MAX_PATTERN-1-i]),
      .en       (32'(len_reg) > i),
      .win      (win_q[i]),
      .pat      (pat_q[i]),
      .ok       (cell_ok[i])
    );
  end

  // sequence counters
  always_comb begin
    seen_next  = (seen == SEEN_W'(MAX_PATTERN)) ? seen : seen + 1'b1;
    hit        = len_ok && (32'(seen_next) >= 32'(len_reg)) && (&cell_ok);
    total_next = (hit && total != '1) ? total + 1'b1 : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      total <= '0;
    end else if (in_fire) begin
      seen  <= s_axis_tlast ? '0 : seen_next;
      total <= s_axis_tlast ? '0 : total_next;
    end
  end

  // output register with skid entry
  assign pop = o_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (!o_valid || pop) begin
        if (s_valid) begin
          o_valid <= 1'b1;
          s_valid <= 1'b0;
        end else begin
          o_valid <= in_fire;
        end
      end else if (in_fire) begin
        s_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || pop) begin
      if (s_valid) begin
        o_hit   <= s_hit;
        o_count <= s_count;
        o_last  <= s_last;
      end else begin
        o_hit   <= hit;
        o_count <= total_next;
        o_last  <= s_axis_tlast;
      end
    end else if (in_fire) begin
      s_hit   <= hit;
      s_count <= total_next;
      s_last  <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;

  always_comb begin
    m_axis_tdata                = '0;
    m_axis_tdata[0]             = o_hit;
    m_axis_tdata[COUNT_WIDTH:1] = o_count;
  end

endmodule

`default_nettype wire

/* rtl/core/dpoc_checker.sv */
// Port-level checks for the DNA pattern occurrence counter core, bound to the top level.
// Depends on dpoc_pkg for defaults and widths.
`timescale 1ns / 1ps
`default_nettype none

module dpoc_checker #(
  parameter int COUNT_WIDTH = dpoc_pkg::DEF_COUNT_WIDTH,
  localparam int OUT_W      = ((1 + COUNT_WIDTH + 7) / 8) * 8
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [OUT_W-1:0]                 m_axis_tdata,  // [0] hit, then match_count
  input wire logic                             m_axis_tlast,  // sequence_done
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready
);
  import dpoc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a configuration write starts pattern alignment, which blocks input
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_axis_tready)
    else $error("input open right after configuration write");

  // a hit always comes with a nonzero count
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[COUNT_WIDTH:1] != '0)
    else $error("hit reported with zero count");

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind dna_pattern_occurrence_counter_core dpoc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);

`default_nettype wire
